>>> design/scim_pkg.sv
// shared constants, codes and key hash for the sparse coordinate index map
`default_nettype none

package scim_pkg;

  localparam int CAPACITY_DEF   = 4096;
  localparam int COORD_BITS_DEF = 32;
  localparam int STEP_W         = 16;
  localparam int BATCH_W        = 16;
  localparam int CNT_W          = 20;
  localparam int INDEX_W        = 21;
  localparam int FIELD_W        = 32;
  localparam int CFG_IDX_W      = 8;
  localparam int HASH_W         = 20;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_LOOKUP  = 2'd1;
  localparam logic [1:0] CMD_QLOOKUP = 2'd2;
  localparam logic [1:0] CMD_CLEAR   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Z = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 8'd3;

  // xor fold of the full key into HASH_W bits
  function automatic logic [HASH_W-1:0] key_hash(input logic [3*FIELD_W+BATCH_W-1:0] key);
    logic [6*HASH_W-1:0] pad;
    logic [HASH_W-1:0]   acc;
    pad = (6*HASH_W)'(key);
    acc = '0;
    for (int i = 0; i < 6; i++) begin
      acc = acc ^ pad[i*HASH_W +: HASH_W] ^ (pad[i*HASH_W +: HASH_W] >> 7);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

>>> design/scim_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none

module scim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/scim_quant.sv
// iterative quantizer: truncates the magnitude to a multiple of step by subtracting the remainder, one bit a cycle
`default_nettype none

module scim_quant import scim_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic signed [COORD_BITS-1:0] coord,
  input  wire logic [STEP_W-1:0]            step,
  output logic                              done,
  output logic signed [COORD_BITS-1:0]      key
);

  localparam int CW = $clog2(COORD_BITS + 1);

  logic [COORD_BITS-1:0] absval;
  logic [COORD_BITS-1:0] shreg;
  logic [STEP_W:0]       rem;
  logic [STEP_W-1:0]     div;
  logic                  neg;
  logic [CW-1:0]         cnt;
  logic                  busy;
  logic [STEP_W:0]       trial;
  logic [COORD_BITS-1:0] qmag;

  assign trial = {rem[STEP_W-1:0], shreg[COORD_BITS-1]};
  // remainder is below the step, so the quantized magnitude is value minus remainder
  assign qmag  = absval - COORD_BITS'(rem);
  assign key   = neg ? -$signed(qmag) : $signed(qmag);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(COORD_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg    <= coord[COORD_BITS-1];
      absval <= coord[COORD_BITS-1] ? COORD_BITS'(-coord) : COORD_BITS'(coord);
      shreg  <= coord[COORD_BITS-1] ? COORD_BITS'(-coord) : COORD_BITS'(coord);
      rem    <= '0;
      div    <= (step == '0) ? STEP_W'(1) : step;
    end else if (busy) begin
      shreg <= shreg << 1;
      rem   <= (trial >= {1'b0, div}) ? trial - {1'b0, div} : trial;
    end
  end

endmodule

`default_nettype wire

>>> design/sparse_coordinate_index_map.sv
// sparse coordinate index map: hashed key store with linear probing
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata x,y,z,batch; tuser command
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata index,key_x..z; tuser hit,status
// cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// one item at a time; a quantized command first runs through the dividers, then each
// probe of the key ram takes a read state and then a compare state. clear and reset
// run a sweep through every slot of the key ram with the input stalled. a result
// waits in the output register while the next word is taken in.
`default_nettype none

module sparse_coordinate_index_map import scim_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [111:0]         s_axis_tdata,  // coord_x, coord_y, coord_z, batch
  input  wire logic [1:0]           s_axis_tuser,  // command
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [119:0]              m_axis_tdata,  // index, key_x, key_y, key_z, zero pad
  output logic [1:0]                m_axis_tuser,  // hit, status
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [STEP_W-1:0]    cfg_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int CB = COORD_BITS;
  localparam int WW = 3*CB + BATCH_W + CNT_W + 1;

  typedef enum logic [7:0] {
    ST_SWEEP = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_DIV   = 8'b0000_0100,
    ST_HASH  = 8'b0000_1000,
    ST_RD    = 8'b0001_0000,
    ST_CMP   = 8'b0010_0000,
    ST_DONE  = 8'b0100_0000
  } state_t;

  state_t state;

  logic [STEP_W-1:0] step_x, step_y, step_z;
  logic              index_mode;
  logic [CNT_W-1:0]  distinct_count, row_count;

  logic [1:0]           cmd;
  logic [BATCH_W-1:0]   bat;
  logic signed [CB-1:0] kx, ky, kz;
  logic [AW-1:0]        probe, sweep_addr;
  logic [PW-1:0]        probe_n;
  logic                 clr_pend;
  logic [INDEX_W-1:0]   r_index;
  logic                 r_hit, r_status;

  logic                 in_acc;
  logic signed [CB-1:0] in_x, in_y, in_z;
  logic                 q_start, qdone_x, qdone_y, qdone_z;
  logic signed [CB-1:0] qx, qy, qz;

  logic          we;
  logic [AW-1:0] waddr;
  logic [WW-1:0] wdata, rdata;

  logic                 rv;
  logic signed [CB-1:0] ex, ey, ez;
  logic [BATCH_W-1:0]   eb;
  logic [CNT_W-1:0]     ei;
  logic                 match, is_ins;
  logic [CNT_W-1:0]     new_idx;
  logic [HASH_W-1:0]    hv;
  logic [AW-1:0]        home;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign in_x = s_axis_tdata[CB-1:0];
  assign in_y = s_axis_tdata[32 +: CB];
  assign in_z = s_axis_tdata[64 +: CB];

  assign q_start = in_acc && (s_axis_tuser == CMD_INSERT || s_axis_tuser == CMD_QLOOKUP);

  scim_quant #(.COORD_BITS(CB)) u_qx (
    .clk(clk), .rst(rst), .start(q_start), .coord(in_x), .step(step_x),
    .done(qdone_x), .key(qx)
  );
  scim_quant #(.COORD_BITS(CB)) u_qy (
    .clk(clk), .rst(rst), .start(q_start), .coord(in_y), .step(step_y),
    .done(qdone_y), .key(qy)
  );
  scim_quant #(.COORD_BITS(CB)) u_qz (
    .clk(clk), .rst(rst), .start(q_start), .coord(in_z), .step(step_z),
    .done(qdone_z), .key(qz)
  );

  // entry word: valid, index, batch, z, y, x
  assign rv = rdata[WW-1];
  assign ex = rdata[CB-1:0];
  assign ey = rdata[CB +: CB];
  assign ez = rdata[2*CB +: CB];
  assign eb = rdata[3*CB +: BATCH_W];
  assign ei = rdata[3*CB+BATCH_W +: CNT_W];

  assign match   = rv && ex == kx && ey == ky && ez == kz && eb == bat;
  assign is_ins  = (cmd == CMD_INSERT);
  assign new_idx = index_mode ? row_count : distinct_count;

  assign hv   = key_hash({bat, 32'(kz), 32'(ky), 32'(kx)});
  assign home = ({1'b0, hv[AW-1:0]} >= (AW+1)'(CAPACITY)) ?
                hv[AW-1:0] - AW'(CAPACITY) : hv[AW-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = probe;
    wdata = {1'b1, new_idx, bat, kz, ky, kx};
    if (state == ST_SWEEP) begin
      we    = 1'b1;
      waddr = sweep_addr;
      wdata = '0;
    end else if (state == ST_CMP && is_ins && !rv) begin
      we = 1'b1;
    end
  end

  scim_ram #(.WIDTH(WW), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(probe), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step_x     <= STEP_W'(1);
      step_y     <= STEP_W'(1);
      step_z     <= STEP_W'(1);
      index_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP_X: step_x     <= cfg_data;
        REG_STEP_Y: step_y     <= cfg_data;
        REG_STEP_Z: step_z     <= cfg_data;
        REG_MODE:   index_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_SWEEP;
      sweep_addr     <= '0;
      clr_pend       <= 1'b0;
      distinct_count <= '0;
      row_count      <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == AW'(CAPACITY - 1)) begin
            sweep_addr <= '0;
            state      <= clr_pend ? ST_DONE : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            cmd <= s_axis_tuser;
            bat <= s_axis_tdata[96 +: BATCH_W];
            kx  <= in_x;
            ky  <= in_y;
            kz  <= in_z;
            r_index  <= '1;
            r_hit    <= 1'b0;
            r_status <= 1'b0;
            case (s_axis_tuser)
              CMD_CLEAR: begin
                kx <= '0;
                ky <= '0;
                kz <= '0;
                r_index        <= '0;
                distinct_count <= '0;
                row_count      <= '0;
                clr_pend       <= 1'b1;
                state          <= ST_SWEEP;
              end
              CMD_LOOKUP: state <= ST_HASH;
              default:    state <= ST_DIV;
            endcase
          end
        end
        ST_DIV: begin
          if (qdone_x && qdone_y && qdone_z) begin
            kx    <= qx;
            ky    <= qy;
            kz    <= qz;
            state <= ST_HASH;
          end
        end
        ST_HASH: begin
          probe   <= home;
          probe_n <= '0;
          state   <= ST_RD;
        end
        ST_RD: state <= ST_CMP;
        ST_CMP: begin
          if (match) begin
            r_hit   <= 1'b1;
            r_index <= {1'b0, (is_ins && index_mode) ? row_count : ei};
            if (is_ins) begin
              row_count <= row_count + 1'b1;
            end
            state <= ST_DONE;
          end else if (!rv) begin
            if (is_ins) begin
              r_index        <= {1'b0, new_idx};
              distinct_count <= distinct_count + 1'b1;
              row_count      <= row_count + 1'b1;
            end
            state <= ST_DONE;
          end else if (probe_n == PW'(CAPACITY - 1)) begin
            // every slot probed and none free
            r_status <= is_ins;
            state    <= ST_DONE;
          end else begin
            probe   <= (probe == AW'(CAPACITY - 1)) ? '0 : probe + 1'b1;
            probe_n <= probe_n + 1'b1;
            state   <= ST_RD;
          end
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {3'b000, 32'(kz), 32'(ky), 32'(kx), r_index};
            m_axis_tuser  <= {r_status, r_hit};
            clr_pend      <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_clear_sweeps: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_axis_tuser == CMD_CLEAR |=> state == ST_SWEEP)
    else $error("clear did not start the sweep");

  a_insert_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP && we |-> !rv)
    else $error("insert overwrote a live entry");

  a_full_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[INDEX_W-1:0] == '1 && !m_axis_tuser[0])
    else $error("full status without miss index");

endmodule

`default_nettype wire
